>>> hw/rtl/mdl_pkg.sv
// Shared constants, register codes and the sequencer state type for the
// midpoint displacement line block. No dependencies.
package mdl_pkg;

  localparam int LINE_LENGTH  = 512;   // default line length, positions 0..LINE_LENGTH
  localparam int STACK_DEPTH  = 10;    // interval stack entries
  localparam int DEPTH_W      = 4;     // interval depth field
  localparam int CFG_W        = 10;    // start_limit and height_ceiling
  localparam int H_W          = 11;    // signed height
  localparam int WORD_W       = 31;    // random word
  localparam int POS_W        = 10;    // position field of a result
  localparam int DIVISOR_W    = CFG_W + 1;  // 2*limit+1
  localparam int MOD_BPC      = 4;     // remainder bits resolved per cycle
  localparam int LIMIT_MIN    = 2;     // below this there is no displacement

  localparam logic [CFG_W-1:0] START_LIMIT_RST = 10'd256;
  localparam logic [CFG_W-1:0] CEILING_RST     = 10'd511;

  // register index on paddr[2]
  localparam logic REG_START_LIMIT    = 1'b0;
  localparam logic REG_HEIGHT_CEILING = 1'b1;

  // op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_WAIT,
    ST_EMIT
  } state_t;

endpackage

>>> hw/rtl/mdl_height_mem.sv
// Height store: one write port, two registered read ports.
// Depends on nothing but its parameters.
module mdl_height_mem #(
  parameter int DEPTH = 513,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hw/rtl/mdl_mod_unit.sv
// Iterative remainder unit: word mod divisor, MOD_BPC bits per cycle.
// Depends on mdl_pkg.
module mdl_mod_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mdl_pkg::WORD_W-1:0]    dividend,
  input  logic [mdl_pkg::DIVISOR_W-1:0] divisor,
  output logic [mdl_pkg::DIVISOR_W-1:0] rem,
  output logic                          done
);

  localparam int DVW   = mdl_pkg::DIVISOR_W;
  localparam int BPC   = mdl_pkg::MOD_BPC;
  localparam int PAD_W = ((mdl_pkg::WORD_W + BPC - 1) / BPC) * BPC;
  localparam int STEPS = PAD_W / BPC;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [PAD_W-1:0] dvd_r, dvd_nxt;
  logic [DVW-1:0]   dsr_r;
  logic [DVW-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVW:0]     cand;
  logic [DVW-1:0]   part;

  // restoring remainder steps over the top BPC dividend bits
  always_comb begin
    part = rem_r;
    cand = '0;
    for (int i = 0; i < BPC; i++) begin
      cand = {part, dvd_r[PAD_W-1-i]};
      if (cand >= {1'b0, dsr_r}) begin
        cand = cand - {1'b0, dsr_r};
      end
      part = cand[DVW-1:0];
    end
    rem_nxt = part;
    dvd_nxt = dvd_r << BPC;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= PAD_W'(dividend);
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

>>> hw/rtl/midpoint_displacement_line.sv
// Top level: sequencer, interval stack, config registers and output register.
// Depends on mdl_pkg, mdl_height_mem and mdl_mod_unit.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tuser op, tdata heights and random word
//  out_     out  out_tvalid/out_tready  tdata position/height, tlast, tuser rejected
//  cfg_     in   APB psel/penable       start_limit @0x0, height_ceiling @0x4
//
// A step word passes through pop, read of both end heights, the remainder
// unit (4 bits per cycle of the 32-bit padded word), the height write and
// pushes, then the output register load. A start word makes two writes on the
// one write port; a rejected step goes straight to the output register load.
// Synchronous active-low reset clears the sequencer, stack pointer and busy
// flag; the height store is not cleared. A finished word waits in the output
// register while the next word is taken; a second finished word holds the
// sequencer, and so in_tready, until the first one is taken.
module midpoint_displacement_line #(
  parameter int LINE_LENGTH = mdl_pkg::LINE_LENGTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // left_height[10:0], right_height[21:11], random_word[52:22]
  input  logic [0:0]  in_tuser,   // op[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // position[9:0], height[20:10]
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // rejected[0]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW    = $clog2(LINE_LENGTH + 1);
  localparam int SD    = mdl_pkg::STACK_DEPTH;
  localparam int SP_W  = $clog2(SD + 1);
  localparam int IDX_W = $clog2(SD);
  localparam int H_W   = mdl_pkg::H_W;
  localparam int CFG_W = mdl_pkg::CFG_W;
  localparam int DW_W  = mdl_pkg::DEPTH_W;
  localparam int DVW   = mdl_pkg::DIVISOR_W;
  localparam int POS_W = mdl_pkg::POS_W;
  localparam int WORD_W = mdl_pkg::WORD_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_LENGTH);

  mdl_pkg::state_t state_r, state_nxt;

  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic             busy_r, busy_nxt;
  logic [AW-1:0]    stk_lo_r  [SD];
  logic [AW-1:0]    stk_hi_r  [SD];
  logic [DW_W-1:0]  stk_dep_r [SD];
  logic [AW-1:0]    stk_lo_nxt  [SD];
  logic [AW-1:0]    stk_hi_nxt  [SD];
  logic [DW_W-1:0]  stk_dep_nxt [SD];

  logic [AW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt, pos_r, pos_nxt;
  logic [DW_W-1:0]   dep_r, dep_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [H_W-1:0]    right_r, right_nxt;

  logic [CFG_W-1:0] start_limit_r, start_limit_nxt;
  logic [CFG_W-1:0] ceiling_r, ceiling_nxt;

  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic [H_W-1:0]   res_h_r, res_h_nxt;
  logic             res_last_r, res_last_nxt;
  logic             res_rej_r, res_rej_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [H_W-1:0]   out_h_r, out_h_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_rej_r, out_rej_nxt;

  // memory and remainder unit hookup
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [H_W-1:0] mem_wdata;
  logic           mem_re;
  logic [H_W-1:0] rd_lo, rd_hi;
  logic           mod_start;
  logic [DVW-1:0] mod_divisor;
  logic [DVW-1:0] mod_rem;
  logic           mod_done;

  // datapath
  logic               in_op;
  logic [H_W-1:0]     in_left, in_right;
  logic [WORD_W-1:0]  in_word;
  logic [CFG_W-1:0]   limit;
  logic [IDX_W-1:0]   top_idx;
  logic signed [H_W:0]   sum_s, rnd_s, avg_s;
  logic signed [H_W+2:0] disp_s, hval_s;
  logic [H_W-1:0]     h_clamped;
  logic               push_r_ok, push_l_ok;
  logic [SP_W-1:0]    sp_mid;
  logic               cfg_wr;

  assign in_op    = in_tuser[0];
  assign in_left  = in_tdata[10:0];
  assign in_right = in_tdata[21:11];
  assign in_word  = in_tdata[52:22];

  assign limit       = start_limit_r >> dep_r;
  assign mod_divisor = {limit, 1'b1};
  assign top_idx     = IDX_W'(sp_r - 1'b1);

  // truncated average of the two ends, plus displacement, then clamp
  always_comb begin
    sum_s  = $signed({rd_lo[H_W-1], rd_lo}) + $signed({rd_hi[H_W-1], rd_hi});
    rnd_s  = sum_s + $signed({{H_W{1'b0}}, sum_s[H_W]});
    avg_s  = rnd_s >>> 1;
    if (limit >= CFG_W'(mdl_pkg::LIMIT_MIN)) begin
      disp_s = $signed({3'b000, mod_rem}) - $signed({4'b0000, limit});
    end else begin
      disp_s = '0;
    end
    hval_s = $signed({{2{avg_s[H_W]}}, avg_s}) + disp_s;
    if (hval_s < 0) begin
      h_clamped = '0;
    end else if (hval_s > $signed({4'b0000, ceiling_r})) begin
      h_clamped = {1'b0, ceiling_r};
    end else begin
      h_clamped = hval_s[H_W-1:0];
    end
  end

  assign push_r_ok = ((hi_r - pos_r) >= AW'(2)) && (sp_r < SP_W'(SD));
  assign sp_mid    = sp_r + SP_W'(push_r_ok);
  assign push_l_ok = ((pos_r - lo_r) >= AW'(2)) && (sp_mid < SP_W'(SD));

  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    state_nxt       = state_r;
    sp_nxt          = sp_r;
    busy_nxt        = busy_r;
    stk_lo_nxt      = stk_lo_r;
    stk_hi_nxt      = stk_hi_r;
    stk_dep_nxt     = stk_dep_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    dep_nxt         = dep_r;
    pos_nxt         = pos_r;
    word_nxt        = word_r;
    right_nxt       = right_r;
    res_pos_nxt     = res_pos_r;
    res_h_nxt       = res_h_r;
    res_last_nxt    = res_last_r;
    res_rej_nxt     = res_rej_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    out_pos_nxt     = out_pos_r;
    out_h_nxt       = out_h_r;
    out_last_nxt    = out_last_r;
    out_rej_nxt     = out_rej_r;
    start_limit_nxt = start_limit_r;
    ceiling_nxt     = ceiling_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mod_start       = 1'b0;
    in_tready       = (state_r == mdl_pkg::ST_IDLE);

    if (cfg_wr) begin
      case (cfg_paddr[2])
        mdl_pkg::REG_START_LIMIT:    start_limit_nxt = cfg_pwdata[CFG_W-1:0];
        mdl_pkg::REG_HEIGHT_CEILING: ceiling_nxt     = cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      mdl_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_op == mdl_pkg::OP_START) begin
            mem_we         = 1'b1;
            mem_waddr      = '0;
            mem_wdata      = in_left;
            right_nxt      = in_right;
            stk_lo_nxt[0]  = '0;
            stk_hi_nxt[0]  = LAST_ADDR;
            stk_dep_nxt[0] = '0;
            sp_nxt         = SP_W'(1);
            busy_nxt       = 1'b1;
            state_nxt      = mdl_pkg::ST_START;
          end else if (!busy_r || sp_r == '0) begin
            busy_nxt     = 1'b0;
            res_pos_nxt  = '0;
            res_h_nxt    = '0;
            res_last_nxt = 1'b0;
            res_rej_nxt  = 1'b1;
            state_nxt    = mdl_pkg::ST_EMIT;
          end else begin
            sp_nxt    = sp_r - 1'b1;
            lo_nxt    = stk_lo_r[top_idx];
            hi_nxt    = stk_hi_r[top_idx];
            dep_nxt   = stk_dep_r[top_idx];
            word_nxt  = in_word;
            state_nxt = mdl_pkg::ST_READ;
          end
        end
      end
      mdl_pkg::ST_START: begin
        mem_we    = 1'b1;
        mem_waddr = LAST_ADDR;
        mem_wdata = right_r;
        state_nxt = mdl_pkg::ST_IDLE;
      end
      mdl_pkg::ST_READ: begin
        mem_re    = 1'b1;
        mod_start = 1'b1;
        pos_nxt   = lo_r + ((hi_r - lo_r) >> 1);
        state_nxt = mdl_pkg::ST_WAIT;
      end
      mdl_pkg::ST_WAIT: begin
        if (mod_done) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r;
          mem_wdata = h_clamped;
          // right half goes under the left half so the left is popped first
          if (push_r_ok) begin
            stk_lo_nxt[IDX_W'(sp_r)]  = pos_r;
            stk_hi_nxt[IDX_W'(sp_r)]  = hi_r;
            stk_dep_nxt[IDX_W'(sp_r)] = dep_r + 1'b1;
          end
          if (push_l_ok) begin
            stk_lo_nxt[IDX_W'(sp_mid)]  = lo_r;
            stk_hi_nxt[IDX_W'(sp_mid)]  = pos_r;
            stk_dep_nxt[IDX_W'(sp_mid)] = dep_r + 1'b1;
          end
          sp_nxt       = sp_mid + SP_W'(push_l_ok);
          res_last_nxt = (sp_mid + SP_W'(push_l_ok)) == '0;
          if ((sp_mid + SP_W'(push_l_ok)) == '0) begin
            busy_nxt = 1'b0;
          end
          res_pos_nxt = POS_W'(pos_r);
          res_h_nxt   = h_clamped;
          res_rej_nxt = 1'b0;
          state_nxt   = mdl_pkg::ST_EMIT;
        end
      end
      mdl_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = res_pos_r;
          out_h_nxt     = res_h_r;
          out_last_nxt  = res_last_r;
          out_rej_nxt   = res_rej_r;
          state_nxt     = mdl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mdl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mdl_pkg::ST_IDLE;
      sp_r          <= '0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      start_limit_r <= mdl_pkg::START_LIMIT_RST;
      ceiling_r     <= mdl_pkg::CEILING_RST;
    end else begin
      state_r       <= state_nxt;
      sp_r          <= sp_nxt;
      busy_r        <= busy_nxt;
      out_valid_r   <= out_valid_nxt;
      start_limit_r <= start_limit_nxt;
      ceiling_r     <= ceiling_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stk_lo_r   <= stk_lo_nxt;
    stk_hi_r   <= stk_hi_nxt;
    stk_dep_r  <= stk_dep_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    dep_r      <= dep_nxt;
    pos_r      <= pos_nxt;
    word_r     <= word_nxt;
    right_r    <= right_nxt;
    res_pos_r  <= res_pos_nxt;
    res_h_r    <= res_h_nxt;
    res_last_r <= res_last_nxt;
    res_rej_r  <= res_rej_nxt;
    out_pos_r  <= out_pos_nxt;
    out_h_r    <= out_h_nxt;
    out_last_r <= out_last_nxt;
    out_rej_r  <= out_rej_nxt;
  end

  mdl_height_mem #(
    .DEPTH (LINE_LENGTH + 1),
    .AW    (AW),
    .DW    (H_W)
  ) u_height_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (lo_r),
    .raddr_b (hi_r),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  mdl_mod_unit u_mod_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (word_r),
    .divisor  (mod_divisor),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_h_r, out_pos_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_rej_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == mdl_pkg::REG_START_LIMIT) ?
                      {{(32 - CFG_W){1'b0}}, start_limit_r} :
                      {{(32 - CFG_W){1'b0}}, ceiling_r};

endmodule

>>> dv/testbench.sv
// Self-checking testbench for midpoint_displacement_line: predicts every midpoint
// word, drives random bursts and stalls. Depends on mdl_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 40;    // covers a start word still in flight
  localparam int HOLD_CYCLES   = 400;

  typedef struct {
    logic               op;
    logic signed [10:0] left_h;
    logic signed [10:0] right_h;
    logic [30:0]        word;
  } line_word_t;

  typedef struct {
    logic [9:0]         position;
    logic signed [10:0] height;
    logic               last;
    logic               rejected;
  } midpoint_t;

  typedef struct {
    int lo;
    int hi;
    int depth;
  } span_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // left_height[10:0], right_height[21:11], random_word[52:22]
  logic [0:0]  in_tuser = '0;   // op[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // position[9:0], height[20:10]
  logic        out_tlast;
  logic [0:0]  out_tuser;       // rejected[0]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  midpoint_displacement_line dut (.*);

  always #2 clk = ~clk;

  // predictor state
  int        line_heights [0:mdl_pkg::LINE_LENGTH];
  span_t     span_stack [mdl_pkg::STACK_DEPTH];
  int        span_count = 0;
  bit        line_open = 1'b0;
  int        cur_start_limit = 256;
  int        cur_ceiling = 511;
  midpoint_t expected_midpoints [$];

  line_word_t pending_words [$];
  int words_queued = 0;
  int words_accepted = 0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_started = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 50)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void push_span(input int lo, input int hi, input int depth);
    if (hi - lo < 2 || span_count >= mdl_pkg::STACK_DEPTH)
      return;
    span_stack[span_count] = '{lo, hi, depth};
    span_count++;
  endfunction

  function automatic void predict_midpoint(input line_word_t w);
    span_t       s;
    midpoint_t   m;
    int          h;
    int          lim;
    int          pos;
    int unsigned rem;
    if (w.op == mdl_pkg::OP_START) begin
      line_heights[0] = w.left_h;
      line_heights[mdl_pkg::LINE_LENGTH] = w.right_h;
      span_count = 0;
      push_span(0, mdl_pkg::LINE_LENGTH, 0);
      line_open = (span_count != 0);
      return;
    end
    m = '{default: '0};
    if (!line_open || span_count == 0) begin
      line_open = 1'b0;
      m.rejected = 1'b1;
      expected_midpoints.push_back(m);
      return;
    end
    span_count--;
    s = span_stack[span_count];
    pos = s.lo + (s.hi - s.lo) / 2;
    h = (line_heights[s.lo] + line_heights[s.hi]) / 2;
    lim = (s.depth < 31) ? (cur_start_limit >> s.depth) : 0;
    if (lim >= mdl_pkg::LIMIT_MIN) begin
      rem = w.word % (2 * lim + 1);
      h = h + int'(rem) - lim;
    end
    if (h > cur_ceiling)
      h = cur_ceiling;
    else if (h < 0)
      h = 0;
    line_heights[pos] = h;
    push_span(pos, s.hi, s.depth + 1);
    push_span(s.lo, pos, s.depth + 1);
    m.position = pos[9:0];
    m.height = h[10:0];
    m.last = (span_count == 0);
    if (m.last)
      line_open = 1'b0;
    expected_midpoints.push_back(m);
  endfunction

  function automatic void queue_word(input logic op, input int left, input int right,
                                     input int unsigned word);
    line_word_t w;
    w.op = op;
    w.left_h = left[10:0];
    w.right_h = right[10:0];
    w.word = word[30:0];
    pending_words.push_back(w);
    words_queued++;
  endfunction

  function automatic int unsigned rand_word();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 4096);
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic int rand_height();
    return $urandom_range(0, 2047) - 1024;
  endfunction

  function automatic void queue_start();
    queue_word(mdl_pkg::OP_START, rand_height(), rand_height(), $urandom);
  endfunction

  function automatic void queue_step();
    queue_word(mdl_pkg::OP_STEP, rand_height(), rand_height(), rand_word());
  endfunction

  // mostly lines with random content, some lone starts and stray steps
  function automatic void queue_random_lines(input int n_words);
    int made;
    int steps;
    made = 0;
    while (made < n_words) begin
      case ($urandom_range(0, 9))
        0: begin
          queue_step();
          made++;
        end
        1: begin
          queue_start();
          made++;
        end
        default: begin
          steps = $urandom_range(1, 12);
          queue_start();
          repeat (steps) queue_step();
          made += steps + 1;
        end
      endcase
    end
  endfunction

  task automatic write_reg(input logic reg_sel, input int value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_sel == mdl_pkg::REG_START_LIMIT)
      cur_start_limit = value & 32'h3FF;
    else
      cur_start_limit = cur_start_limit;
    if (reg_sel == mdl_pkg::REG_HEIGHT_CEILING)
      cur_ceiling = value & 32'h3FF;
  endtask

  task automatic settle();
    while (words_accepted != words_queued || expected_midpoints.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_setting(input int limit_val, input int ceiling_val, input int n_words);
    write_reg(mdl_pkg::REG_START_LIMIT, limit_val);
    write_reg(mdl_pkg::REG_HEIGHT_CEILING, ceiling_val);
    queue_random_lines(n_words);
    settle();
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin : driver
    line_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= w.op;
        in_tdata <= {3'b000, w.word, w.right_h, w.left_h};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // receiver: stall modes that change every so often, plus requested long holds
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_started != holds_asked) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    line_word_t w;
    midpoint_t  got;
    midpoint_t  want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        w.op = in_tuser[0];
        w.left_h = in_tdata[10:0];
        w.right_h = in_tdata[21:11];
        w.word = in_tdata[52:22];
        predict_midpoint(w);
        words_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got.position = out_tdata[9:0];
        got.height = out_tdata[20:10];
        got.last = out_tlast;
        got.rejected = out_tuser[0];
        if (expected_midpoints.size() == 0) begin
          report_mismatch("result word with none pending, position", got.position, -1);
        end else begin
          want = expected_midpoints.pop_front();
          if (got.position != want.position)
            report_mismatch("position", got.position, want.position);
          if (got.height != want.height)
            report_mismatch("height", got.height, want.height);
          if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
          if (got.rejected != want.rejected)
            report_mismatch("rejected", got.rejected, want.rejected);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: steps with no line, extreme ends and words, line restarts
    queue_word(mdl_pkg::OP_STEP, 1023, -1024, 32'h7FFF_FFFF);
    queue_word(mdl_pkg::OP_STEP, -1024, 1023, 0);
    queue_word(mdl_pkg::OP_START, -1024, 1023, 32'h7FFF_FFFF);
    queue_word(mdl_pkg::OP_STEP, 0, 0, 0);
    queue_word(mdl_pkg::OP_STEP, 0, 0, 32'h7FFF_FFFF);
    queue_word(mdl_pkg::OP_STEP, 0, 0, 512);
    queue_word(mdl_pkg::OP_START, 1023, -1024, 0);
    queue_word(mdl_pkg::OP_STEP, -1, -1, 513);
    queue_word(mdl_pkg::OP_START, 0, 0, 0);
    queue_word(mdl_pkg::OP_STEP, 0, 0, 256);
    queue_word(mdl_pkg::OP_START, -1, -1, 0);
    queue_word(mdl_pkg::OP_STEP, 0, 0, 0);
    queue_word(mdl_pkg::OP_START, 1023, 1023, 0);
    queue_word(mdl_pkg::OP_STEP, 0, 0, 32'h7FFF_FFFF);
    queue_word(mdl_pkg::OP_STEP, 1023, 1023, 32'h5555_5555);
    queue_word(mdl_pkg::OP_STEP, -1024, -1024, 32'h2AAA_AAAA);
    settle();

    // one complete line, then steps past its end; a long output hold meanwhile
    write_reg(mdl_pkg::REG_START_LIMIT, 1023);
    write_reg(mdl_pkg::REG_HEIGHT_CEILING, 1023);
    queue_start();
    repeat (mdl_pkg::LINE_LENGTH - 1) queue_step();
    repeat (3) queue_step();
    holds_asked++;
    settle();

    run_setting(0, 0, 8);
    run_setting(1, 1023, 8);
    run_setting(2, 300, 8);
    run_setting($urandom_range(0, 1023), $urandom_range(0, 1023), 8);
    run_setting($urandom_range(0, 1023), $urandom_range(0, 1023), 8);
    run_setting(256, 511, 8);

    if (expected_midpoints.size() != 0)
      report_mismatch("result words never delivered", 0, expected_midpoints.size());
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mdl_pkg.sv
hw/rtl/mdl_height_mem.sv
hw/rtl/mdl_mod_unit.sv
hw/rtl/midpoint_displacement_line.sv
dv/testbench.sv
